FILE: hw/rtl/ettv_pkg.sv
package ettv_pkg;

   // Fixed field geometry: 4096 counts a turn, 16-bit turn counter.
   localparam int ANGLE_BITS = 12;
   localparam int TURN_BITS  = 16;
   localparam int POS_BITS   = ANGLE_BITS + TURN_BITS;
   localparam int TIME_BITS  = 32;
   localparam int VEL_BITS   = 32;
   localparam int PERIOD_BITS = 16;
   localparam int CSR_DATA_BITS = 16;

   // |dp| * 1e6 fits in 48 bits (|dp| < 2^28, 1e6 < 2^20).
   localparam int SCALE_BITS = 20;
   localparam logic [SCALE_BITS-1:0] US_PER_SEC = SCALE_BITS'(1000000);
   localparam int NUM_BITS  = POS_BITS + SCALE_BITS;
   localparam int DIV_STEPS = NUM_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS);

   localparam logic [ANGLE_BITS-1:0]  WRAP_THRESHOLD_RESET = ANGLE_BITS'(3276);
   localparam logic [PERIOD_BITS-1:0] DEFAULT_PERIOD_RESET = PERIOD_BITS'(1000);

   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

   localparam logic [VEL_BITS-1:0] VEL_POS_SAT = {1'b0, {(VEL_BITS-1){1'b1}}};
   localparam logic [VEL_BITS-1:0] VEL_NEG_SAT = {1'b1, {(VEL_BITS-1){1'b0}}};

   // Register indexes
   localparam logic CSR_WRAP_THRESHOLD = 1'b0;
   localparam logic CSR_DEFAULT_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FIN
   } ettv_state_type;

endpackage

FILE: hw/rtl/ettv_ifs.sv
interface ettv_req_if import ettv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] raw_angle;
   logic [TIME_BITS-1:0]  timestamp_us;
   logic                  velocity_request;

   modport source (output valid, raw_angle, timestamp_us, velocity_request, input ready);
   modport sink   (input valid, raw_angle, timestamp_us, velocity_request, output ready);
endinterface

interface ettv_rsp_if import ettv_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [ANGLE_BITS-1:0]        single_turn_angle;
   logic signed [TURN_BITS-1:0]  turn_count;
   logic signed [POS_BITS-1:0]   multi_turn_position;
   logic signed [VEL_BITS-1:0]   velocity_cps;
   logic                         velocity_valid;

   modport source (output valid, single_turn_angle, turn_count, multi_turn_position,
                   velocity_cps, velocity_valid, input ready);
   modport sink   (input valid, single_turn_angle, turn_count, multi_turn_position,
                   velocity_cps, velocity_valid, output ready);
endinterface

FILE: hw/rtl/encoder_turn_tracker_velocity.sv
// Sequence: intake, then finish without a velocity request, or intake, multiply,
//    48 divide steps and finish with one; finish waits for a free output register.
// Intake: a new item is taken only in idle, once the last one is through; a single
//    restoring divider, one quotient bit a cycle, sets the velocity figure.
// Reset: synchronous, active high; clears tracking state, snapshot and control,
//    and loads the register reset values (threshold 3276, period 1000 us).
module encoder_turn_tracker_velocity
   import ettv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   ettv_req_if.sink                 req_ch,
   ettv_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   ettv_state_type state_ff, state_in;

   // configuration
   logic [ANGLE_BITS-1:0]  wrap_thr_ff;
   logic [PERIOD_BITS-1:0] dflt_period_ff;

   // tracking state
   logic                        primed_ff, primed_in;
   logic [ANGLE_BITS-1:0]       last_angle_ff, last_angle_in;
   logic signed [TURN_BITS-1:0] turns_ff, turns_in;
   logic signed [POS_BITS-1:0]  snap_pos_ff, snap_pos_in;
   logic [TIME_BITS-1:0]        snap_time_ff, snap_time_in;

   // velocity datapath
   logic                   vreq_ff, vreq_in;      // this item wants a velocity
   logic                   neg_ff, neg_in;        // sign of position change
   logic [POS_BITS-1:0]    absdp_ff, absdp_in;    // |position change|
   logic [TIME_BITS-1:0]   dt_ff, dt_in;          // divisor, never zero
   logic [NUM_BITS-1:0]    num_ff, num_in;        // dividend, then quotient
   logic [TIME_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_BITS-1:0]       rsp_angle_ff, rsp_angle_in;
   logic signed [TURN_BITS-1:0] rsp_turns_ff, rsp_turns_in;
   logic signed [POS_BITS-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [VEL_BITS-1:0]         rsp_vel_ff, rsp_vel_in;
   logic                        rsp_vvalid_ff, rsp_vvalid_in;

   // ---------------------------------------------------------------------
   // Intake arithmetic on the offered sample
   // ---------------------------------------------------------------------
   logic                        req_xfer;
   logic signed [ANGLE_BITS:0]  jump;
   logic [ANGLE_BITS-1:0]       jump_mag;
   logic                        wrap;
   logic signed [TURN_BITS-1:0] turns_next;
   logic signed [POS_BITS-1:0]  pos_next;
   logic signed [POS_BITS:0]    dp;
   logic [TIME_BITS-1:0]        ts_diff;
   logic [TIME_BITS-1:0]        dflt_dt;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      jump     = $signed({1'b0, req_ch.raw_angle}) - $signed({1'b0, last_angle_ff});
      jump_mag = jump[ANGLE_BITS] ? ANGLE_BITS'(-jump) : jump[ANGLE_BITS-1:0];
      // a large forward jump is a backward wrap and the other way round
      wrap     = jump_mag > wrap_thr_ff;
      turns_next = turns_ff;
      if (!primed_ff) begin
         turns_next = '0;
      end else if (wrap && !jump[ANGLE_BITS]) begin
         if (turns_ff != TURN_MIN) turns_next = turns_ff - TURN_BITS'(1);
      end else if (wrap) begin
         if (turns_ff != TURN_MAX) turns_next = turns_ff + TURN_BITS'(1);
      end
      pos_next = {turns_next, req_ch.raw_angle};
      dp       = {pos_next[POS_BITS-1], pos_next} - {snap_pos_ff[POS_BITS-1], snap_pos_ff};
      ts_diff  = req_ch.timestamp_us - snap_time_ff;
      // a zero default period is taken as one microsecond
      dflt_dt  = (dflt_period_ff == '0) ? TIME_BITS'(1) : TIME_BITS'(dflt_period_ff);
   end

   // ---------------------------------------------------------------------
   // Divider step and output saturation
   // ---------------------------------------------------------------------
   logic [TIME_BITS+1:0] trial;
   logic                 out_free;
   logic [VEL_BITS-1:0]  vel_sat;

   assign trial    = {1'b0, rem_ff, num_ff[NUM_BITS-1]} - {2'b00, dt_ff};
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (neg_ff) begin
         vel_sat = (num_ff > NUM_BITS'(VEL_NEG_SAT)) ? VEL_NEG_SAT
                                                     : -num_ff[VEL_BITS-1:0];
      end else begin
         vel_sat = (num_ff > NUM_BITS'(VEL_POS_SAT)) ? VEL_POS_SAT
                                                     : num_ff[VEL_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      last_angle_in = last_angle_ff;
      turns_in      = turns_ff;
      snap_pos_in   = snap_pos_ff;
      snap_time_in  = snap_time_ff;
      vreq_in       = vreq_ff;
      neg_in        = neg_ff;
      absdp_in      = absdp_ff;
      dt_in         = dt_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_angle_in  = rsp_angle_ff;
      rsp_turns_in  = rsp_turns_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_vvalid_in = rsp_vvalid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               primed_in     = 1'b1;
               last_angle_in = req_ch.raw_angle;
               turns_in      = turns_next;
               vreq_in       = primed_ff && req_ch.velocity_request;
               neg_in        = dp[POS_BITS];
               absdp_in      = dp[POS_BITS] ? POS_BITS'(-dp) : dp[POS_BITS-1:0];
               dt_in         = (ts_diff == '0) ? dflt_dt : ts_diff;
               // first sample primes the snapshot; a request takes a new one
               if (!primed_ff || req_ch.velocity_request) begin
                  snap_pos_in  = pos_next;
                  snap_time_in = req_ch.timestamp_us;
               end
               state_in = (primed_ff && req_ch.velocity_request) ? S_MUL : S_FIN;
            end
         end
         S_MUL: begin
            num_in   = NUM_BITS'(absdp_ff) * NUM_BITS'(US_PER_SEC);
            rem_in   = '0;
            cnt_in   = CNT_BITS'(DIV_STEPS - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring step: one quotient bit shifts in as a dividend bit leaves
            num_in = {num_ff[NUM_BITS-2:0], !trial[TIME_BITS+1]};
            rem_in = trial[TIME_BITS+1] ? {rem_ff[TIME_BITS-2:0], num_ff[NUM_BITS-1]}
                                        : trial[TIME_BITS-1:0];
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_angle_in  = last_angle_ff;
               rsp_turns_in  = turns_ff;
               rsp_pos_in    = {turns_ff, last_angle_ff};
               rsp_vel_in    = vreq_ff ? vel_sat : '0;
               rsp_vvalid_in = vreq_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_thr_ff    <= WRAP_THRESHOLD_RESET;
         dflt_period_ff <= DEFAULT_PERIOD_RESET;
         primed_ff      <= 1'b0;
         last_angle_ff  <= '0;
         turns_ff       <= '0;
         snap_pos_ff    <= '0;
         snap_time_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_WRAP_THRESHOLD: wrap_thr_ff    <= csr_wdata[ANGLE_BITS-1:0];
               CSR_DEFAULT_PERIOD: dflt_period_ff <= csr_wdata[PERIOD_BITS-1:0];
               default:            ;
            endcase
         end
         primed_ff     <= primed_in;
         last_angle_ff <= last_angle_in;
         turns_ff      <= turns_in;
         snap_pos_ff   <= snap_pos_in;
         snap_time_ff  <= snap_time_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      vreq_ff       <= vreq_in;
      neg_ff        <= neg_in;
      absdp_ff      <= absdp_in;
      dt_ff         <= dt_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_turns_ff  <= rsp_turns_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.single_turn_angle   = rsp_angle_ff;
   assign rsp_ch.turn_count          = rsp_turns_ff;
   assign rsp_ch.multi_turn_position = rsp_pos_ff;
   assign rsp_ch.velocity_cps        = rsp_vel_ff;
   assign rsp_ch.velocity_valid      = rsp_vvalid_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_div_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == '0) |=> (state_ff == S_FIN))
      else $error("divider did not hand over to finish");

   a_fin_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded into output register");

   a_turn_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (turns_ff == $past(turns_ff) ||
                         turns_ff == $past(turns_ff) + TURN_BITS'(1) ||
                         turns_ff == $past(turns_ff) - TURN_BITS'(1)))
      else $error("turn counter moved by more than one");

   a_unprimed_no_vel : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !primed_ff) |=> (state_ff == S_FIN && !vreq_ff))
      else $error("priming sample started a velocity computation");

endmodule
